// ===== rtl/core/fpa_pkg.sv =====
// Shared types and constants for the fixed partition allocator.
package fpa_pkg;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_ALLOC = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    FIT_FIRST = 2'd0,
    FIT_BEST  = 2'd1,
    FIT_NEXT  = 2'd2
  } fit_policy_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_e;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_FIT_POLICY  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 4'd1;

  localparam logic [4:0] BLOCK_COUNT_RST = 5'd16;

  typedef struct packed {
    cmd_e        command;
    logic [3:0]  block_index;
    logic [15:0] block_size;
    logic [15:0] request_size;
  } req_t;

  typedef struct packed {
    logic       granted;
    logic [3:0] chosen_block;
    logic [7:0] request_number;
  } rsp_t;

  typedef struct packed {
    logic        go;
    fit_policy_e policy;
  } scan_ctrl_t;

  typedef struct packed {
    logic done;
    logic found;
  } scan_stat_t;

endpackage

// ===== rtl/core/fixed_partition_allocator_core.sv =====
// Top level of the fixed partition allocator: command sequencer, state and table.
//
// Commands arrive as beats on the req channel (valid/ready). Each command gives
// exactly one beat on the rsp channel, in order. A load writes one partition size
// into the size RAM; a clear drops all busy marks, the request counter and the
// next-fit pointer; an allocate grants a partition in use if one fits.
// Configuration (fit policy, partitions in use) is written on the cfg channel,
// which is always ready; write it only while no command is in flight.
// A load or clear goes from accept straight to the emit step; an allocate first
// scans the partitions in use: the scan reads the size RAM one entry per cycle
// through its single read port and compares each entry in the cycle after its
// read. The next command is taken in the cycle the result shows. One command
// is in progress at a time.
// The result register decouples the two sides: the next command is accepted
// while a result still waits; a stalled receiver holds the block in its emit step
// once the next result is ready.
// Reset clears busy marks, counter and pointer, sets first fit and 16 partitions;
// partition sizes are undefined until loaded.
module fixed_partition_allocator_core #(
  parameter int MAX_BLOCKS = 16,
  parameter int SIZE_BITS  = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_ready,
  input  fpa_pkg::req_t                       req_data,
  output logic                                rsp_valid,
  input  logic                                rsp_ready,
  output fpa_pkg::rsp_t                       rsp_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [fpa_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [fpa_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int IDX_W = $clog2(MAX_BLOCKS);
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

  fpa_pkg::state_e      state;
  fpa_pkg::state_e      state_next;
  fpa_pkg::fit_policy_e fit_policy;
  logic [4:0]           block_count;
  logic [MAX_BLOCKS-1:0] busy;
  logic [IDX_W-1:0]     next_pointer;
  logic [7:0]           request_count;
  fpa_pkg::rsp_t        result;

  logic                 accept;
  logic                 emit_fire;
  logic [CNT_W-1:0]     used;
  logic [IDX_W-1:0]     scan_start;
  logic [CNT_W-1:0]     pick_inc;
  logic                 ram_we;
  logic                 ram_re;
  logic [IDX_W-1:0]     ram_raddr;
  logic [SIZE_BITS-1:0] ram_rdata;
  logic [IDX_W-1:0]     pick;
  fpa_pkg::scan_ctrl_t  scan_ctrl;
  fpa_pkg::scan_stat_t  scan_stat;

  assign cfg_ready = 1'b1;

  assign used = (block_count > MAX_BLOCKS) ? CNT_W'(MAX_BLOCKS) : CNT_W'(block_count);
  assign scan_start = ((fit_policy == fpa_pkg::FIT_NEXT) && (CNT_W'(next_pointer) < used))
                      ? next_pointer : '0;
  assign pick_inc = CNT_W'(pick) + CNT_W'(1);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      fpa_pkg::ST_IDLE: begin
        if (req_valid) begin
          state_next = (req_data.command == fpa_pkg::CMD_ALLOC) ? fpa_pkg::ST_SCAN
                                                                : fpa_pkg::ST_EMIT;
        end
      end
      fpa_pkg::ST_SCAN: begin
        if (scan_stat.done) begin
          state_next = fpa_pkg::ST_EMIT;
        end
      end
      fpa_pkg::ST_EMIT: begin
        if (!rsp_valid || rsp_ready) begin
          state_next = fpa_pkg::ST_IDLE;
        end
      end
      default: state_next = fpa_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    req_ready = 1'b0;
    emit_fire = 1'b0;
    unique case (state)
      fpa_pkg::ST_IDLE: req_ready = 1'b1;
      fpa_pkg::ST_SCAN: ;
      fpa_pkg::ST_EMIT: emit_fire = !rsp_valid || rsp_ready;
      default: ;
    endcase
  end

  assign accept = req_valid && req_ready;

  assign scan_ctrl.go     = accept && (req_data.command == fpa_pkg::CMD_ALLOC);
  assign scan_ctrl.policy = fit_policy;

  assign ram_we = accept && (req_data.command == fpa_pkg::CMD_LOAD) &&
                  (req_data.block_index < MAX_BLOCKS);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= fpa_pkg::ST_IDLE;
      fit_policy    <= fpa_pkg::FIT_FIRST;
      block_count   <= fpa_pkg::BLOCK_COUNT_RST;
      busy          <= '0;
      next_pointer  <= '0;
      request_count <= '0;
      rsp_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        unique case (cfg_index)
          fpa_pkg::CFG_FIT_POLICY:  fit_policy  <= fpa_pkg::fit_policy_e'(cfg_data[1:0]);
          fpa_pkg::CFG_BLOCK_COUNT: block_count <= cfg_data[4:0];
          default: ;
        endcase
      end
      if (accept) begin
        unique case (req_data.command)
          fpa_pkg::CMD_ALLOC: begin
            if (request_count != 8'hff) begin
              request_count <= request_count + 8'd1;
            end
          end
          fpa_pkg::CMD_CLEAR: begin
            busy          <= '0;
            request_count <= '0;
            next_pointer  <= '0;
          end
          default: ;
        endcase
      end
      if ((state == fpa_pkg::ST_SCAN) && scan_stat.done && scan_stat.found) begin
        busy[pick] <= 1'b1;
        if (fit_policy == fpa_pkg::FIT_NEXT) begin
          next_pointer <= (pick_inc == used) ? '0 : IDX_W'(pick_inc);
        end
      end
      if (emit_fire) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // result and output payload
  always_ff @(posedge clk) begin
    if (accept) begin
      result <= '0;
    end else if ((state == fpa_pkg::ST_SCAN) && scan_stat.done) begin
      result.granted        <= scan_stat.found;
      result.chosen_block   <= scan_stat.found ? 4'(pick) : 4'd0;
      result.request_number <= request_count;
    end
    if (emit_fire) begin
      rsp_data <= result;
    end
  end

  fpa_ram #(
    .WIDTH (SIZE_BITS),
    .DEPTH (MAX_BLOCKS)
  ) u_size_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (IDX_W'(req_data.block_index)),
    .wdata (SIZE_BITS'(req_data.block_size)),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  fpa_scan #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .SIZE_BITS  (SIZE_BITS)
  ) u_scan (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (scan_ctrl),
    .used    (used),
    .start   (scan_start),
    .request (SIZE_BITS'(req_data.request_size)),
    .busy    (busy),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata),
    .stat    (scan_stat),
    .pick    (pick)
  );

endmodule

// ===== rtl/core/fpa_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module fpa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/fpa_scan.sv =====
// Partition scan engine: walks the size table one entry per cycle and picks a fit.
module fpa_scan #(
  parameter int MAX_BLOCKS = 16,
  parameter int SIZE_BITS  = 16,
  localparam int IDX_W = $clog2(MAX_BLOCKS),
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  fpa_pkg::scan_ctrl_t    ctrl,
  input  logic [CNT_W-1:0]       used,
  input  logic [IDX_W-1:0]       start,
  input  logic [SIZE_BITS-1:0]   request,
  input  logic [MAX_BLOCKS-1:0]  busy,
  output logic                   rd_en,
  output logic [IDX_W-1:0]       rd_addr,
  input  logic [SIZE_BITS-1:0]   rd_data,
  output fpa_pkg::scan_stat_t    stat,
  output logic [IDX_W-1:0]       pick
);

  logic                 active;
  logic [IDX_W-1:0]     issue_idx;
  logic [CNT_W-1:0]     issue_left;
  logic                 eval_valid;
  logic                 eval_last;
  logic [IDX_W-1:0]     eval_idx;
  logic                 best_mode;
  logic [SIZE_BITS-1:0] req;
  logic                 found;
  logic [SIZE_BITS-1:0] best_left;
  logic                 done;

  logic                 fits;
  logic [SIZE_BITS-1:0] left;
  logic                 take;
  logic [CNT_W-1:0]     idx_inc;

  assign rd_en   = active;
  assign rd_addr = issue_idx;
  assign idx_inc = CNT_W'(issue_idx) + CNT_W'(1);

  // busy marks are stable during a scan, so the flop vector is read at the eval stage
  assign fits = !busy[eval_idx] && (req <= rd_data);
  assign left = rd_data - req;
  // first and next fit keep the first hit; best fit keeps strictly smaller leftovers
  assign take = eval_valid && fits && (!found || (best_mode && (left < best_left)));

  always_ff @(posedge clk) begin
    if (rst) begin
      active     <= 1'b0;
      eval_valid <= 1'b0;
      eval_last  <= 1'b0;
      found      <= 1'b0;
      done       <= 1'b0;
    end else begin
      done       <= (ctrl.go && (used == '0)) || (eval_valid && eval_last);
      eval_valid <= active;
      eval_last  <= active && (issue_left == CNT_W'(1));
      eval_idx   <= issue_idx;
      if (ctrl.go) begin
        active     <= (used != '0);
        issue_idx  <= start;
        issue_left <= used;
        best_mode  <= (ctrl.policy == fpa_pkg::FIT_BEST);
        req        <= request;
        found      <= 1'b0;
      end else begin
        if (active) begin
          issue_idx  <= (idx_inc == used) ? '0 : IDX_W'(idx_inc);
          issue_left <= issue_left - CNT_W'(1);
          if (issue_left == CNT_W'(1)) begin
            active <= 1'b0;
          end
        end
        if (take) begin
          found     <= 1'b1;
          pick      <= eval_idx;
          best_left <= left;
        end
      end
    end
  end

  assign stat.done  = done;
  assign stat.found = found;

endmodule
